// ===== rtl/rspn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspn_pkg: shared types and constants for the radix symbol number parser
// Holds field widths, character codes, register indexes, the parse phase
// enum and the structs passed between the front, queue and back sections.
// ----------------------------------------------------------------------------
package rspn_pkg;

  localparam int MaxSymbols = 16;
  localparam int SymW       = 8;
  localparam int ValW       = 32;
  localparam int PosW       = 4;
  localparam int CntW       = 5;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int MulW       = ValW + CntW;
  localparam int MinRadix   = 2;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  localparam logic [SymW-1:0] ChSpace = 8'd32;
  localparam logic [SymW-1:0] ChTab   = 8'd9;
  localparam logic [SymW-1:0] ChCr    = 8'd13;
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYMBOLS_LOW  = 2'd0,
    CFG_SYMBOLS_HIGH = 2'd1,
    CFG_SYMBOL_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // Alphabet as seen by the datapath
  typedef struct packed {
    logic [MaxSymbols-1:0][SymW-1:0] sym;
    logic [CntW-1:0]                 radix;
    logic                            bad;
  } cfg_t;

  // One classified character
  typedef struct packed {
    logic            last;
    logic            ws;
    logic            found;
    logic [PosW-1:0] pos;
  } item_t;

endpackage

// ===== rtl/rspn_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspn_cfg: alphabet registers and alphabet check
// Stores the symbol bytes and count, clamps the radix and registers a flag
// that marks an unusable alphabet.
// ----------------------------------------------------------------------------
module rspn_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rspn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rspn_pkg::CfgDataW-1:0] cfg_data_i,
  output rspn_pkg::cfg_t                cfg_o
);
  import rspn_pkg::*;

  logic [CfgDataW-1:0]             sym_lo_q;
  logic [CfgDataW-1:0]             sym_hi_q;
  logic [CntW-1:0]                 count_q;
  logic                            bad_q;
  logic                            bad_d;
  logic [CntW-1:0]                 radix;
  logic [MaxSymbols-1:0][SymW-1:0] sym;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      count_q  <= '0;
      bad_q    <= 1'b1;
    end else begin
      bad_q <= bad_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SYMBOLS_LOW:  sym_lo_q <= cfg_data_i;
          CFG_SYMBOLS_HIGH: sym_hi_q <= cfg_data_i;
          CFG_SYMBOL_COUNT: count_q  <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign sym   = {sym_hi_q, sym_lo_q};
  assign radix = (count_q > CntW'(MaxSymbols)) ? CntW'(MaxSymbols) : count_q;

  // Too few symbols, a sign symbol or a duplicate in use marks it bad
  always_comb begin
    bad_d = (radix < CntW'(MinRadix));
    for (int j = 0; j < MaxSymbols; j++) begin
      if (CntW'(j) < radix) begin
        if (sym[j] == ChPlus || sym[j] == ChMinus) bad_d = 1'b1;
        for (int i = 0; i < j; i++) begin
          if (sym[i] == sym[j]) bad_d = 1'b1;
        end
      end
    end
  end

  assign cfg_o.sym   = sym;
  assign cfg_o.radix = radix;
  assign cfg_o.bad   = bad_q;

endmodule

// ===== rtl/rspn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspn_front: input side
// Accepts characters and classifies each as whitespace and as an alphabet
// symbol with its lowest position, then pushes it into the queue.
// ----------------------------------------------------------------------------
module rspn_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rspn_pkg::SymW-1:0]  char_in_i,
  input  logic                       is_last_i,
  input  rspn_pkg::cfg_t             cfg_i,
  input  logic                       full_i,
  output logic                       push_o,
  output rspn_pkg::item_t            item_o
);
  import rspn_pkg::*;

  logic            found;
  logic [PosW-1:0] pos;

  // Scan from the top so the lowest matching position wins
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int k = MaxSymbols - 1; k >= 0; k--) begin
      if (CntW'(k) < cfg_i.radix && cfg_i.sym[k] == char_in_i) begin
        found = 1'b1;
        pos   = PosW'(k);
      end
    end
  end

  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i && !full_i;
  assign item_o.last  = is_last_i;
  assign item_o.ws    = (char_in_i == ChSpace) || (char_in_i >= ChTab && char_in_i <= ChCr);
  assign item_o.found = found;
  assign item_o.pos   = pos;

endmodule

// ===== rtl/rspn_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspn_fifo: classified item queue
// Two-entry queue between the front and back sections.
// ----------------------------------------------------------------------------
module rspn_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rspn_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output rspn_pkg::item_t item_o,
  output logic            empty_o
);
  import rspn_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QueueCntW'(1);
        2'b01:   count_q <= count_q - QueueCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/rspn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspn_back: parse engine
// Pops classified items, runs the parse phase machine and accumulator, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module rspn_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rspn_pkg::item_t                 item_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  input  rspn_pkg::cfg_t                  cfg_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [rspn_pkg::ValW-1:0] value_o,
  output logic                            alphabet_bad_o
);
  import rspn_pkg::*;

  phase_e          phase_q, phase_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] value_q;
  logic            bad_q;
  logic            out_free;
  logic            load_out;
  logic [MulW-1:0] prod;
  logic [ValW-1:0] mac;
  logic            take_digit;
  logic [ValW-1:0] acc_last;

  assign prod = MulW'(acc_q) * MulW'(cfg_i.radix);
  assign mac  = prod[ValW-1:0] + ValW'(item_i.pos);

  // Output side handshake
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    pop_o       = !empty_i && (!item_i.last || out_free);
    load_out    = pop_o && item_i.last;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  // Phase and accumulator update
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    take_digit = 1'b0;
    if (pop_o) begin
      case (phase_q)
        PH_SKIP: begin
          if (!item_i.ws) begin
            if (item_i.found) begin
              take_digit = 1'b1;
              phase_d    = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (item_i.found) take_digit = 1'b1;
          else phase_d = PH_DONE;
        end
        default: phase_d = PH_DONE;
      endcase
      if (take_digit) acc_d = mac;
      if (item_i.last) begin
        phase_d = PH_SKIP;
        acc_d   = '0;
      end
    end
  end

  // Accumulator including the last character, before the restart
  assign acc_last = take_digit ? mac : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      bad_q   <= cfg_i.bad;
      value_q <= cfg_i.bad ? '0 : acc_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign alphabet_bad_o = bad_q;

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> value_q == '0)
    else $error("bad alphabet with nonzero value");
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> phase_q == PH_SKIP && acc_q == '0)
    else $error("parser not restarted after last transfer");
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE && !load_out |=> phase_q == PH_DONE && $stable(acc_q))
    else $error("left done phase without last transfer");
`endif

endmodule

// ===== rtl/radix_symbol_number_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_symbol_number_parser_unit: number parser over a configured alphabet
// Reads one character per transfer and returns the parsed value on the
// transfer marked last.
// ----------------------------------------------------------------------------
// Path: a last character is classified into the queue, then accumulated
//   into the output register, where its result is held until taken.
// Throughput: one character per cycle while in_stall_o is low, set by the
//   combinational 32x5 multiply-add in rspn_back and the two-entry queue.
// Reset: clears the alphabet registers (alphabet reads as bad until written),
//   the parse phase, the accumulator, the queue and the output valid.
module radix_symbol_number_parser_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [rspn_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rspn_pkg::CfgDataW-1:0]    cfg_data_i,
  // character input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rspn_pkg::SymW-1:0]        char_in_i,
  input  logic                             is_last_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rspn_pkg::ValW-1:0] value_o,
  output logic                             alphabet_bad_o
);
  import rspn_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  // Alphabet registers; the bad flag is registered from the stored alphabet
  rspn_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Classify each character against all symbols in parallel
  rspn_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .is_last_i  (is_last_i),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Decouple input stalls from output stalls
  rspn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  // Advance the parse phase and accumulator; hold results until taken
  rspn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .empty_i        (empty),
    .pop_o          (pop),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .alphabet_bad_o (alphabet_bad_o)
  );

endmodule
